### src/sfe_pkg.sv
package sfe_pkg;

  localparam logic [7:0]  SlipEnd    = 8'hC0;
  localparam logic [7:0]  SlipEsc    = 8'hDB;
  localparam logic [7:0]  SlipEscEnd = 8'hDC;
  localparam logic [7:0]  SlipEscEsc = 8'hDD;
  localparam logic [15:0] CrcPoly    = 16'hA001;
  localparam logic [15:0] CrcSeed    = 16'hFFFF;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Wire byte positions of one item, in emission order.
  typedef enum logic [2:0] {
    SLOT_OPEN,
    SLOT_DATA,
    SLOT_DATA_ESC,
    SLOT_CRCL,
    SLOT_CRCL_ESC,
    SLOT_CRCH,
    SLOT_CRCH_ESC,
    SLOT_CLOSE
  } slot_e;

  localparam int unsigned NumSlots = 8;

  typedef struct packed {
    logic [NumSlots-1:0] mask;
    logic [7:0]          data;
    logic [15:0]         crc;
  } cmd_t;

  function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic needs_esc(logic [7:0] b);
    return (b == SlipEnd) || (b == SlipEsc);
  endfunction

  function automatic logic [7:0] esc_first(logic [7:0] b);
    return needs_esc(b) ? SlipEsc : b;
  endfunction

  function automatic logic [7:0] esc_second(logic [7:0] b);
    return (b == SlipEnd) ? SlipEscEnd : SlipEscEsc;
  endfunction

  function automatic logic [7:0] slot_byte(slot_e slot, cmd_t cmd);
    logic [7:0] r;
    case (slot)
      SLOT_OPEN:     r = SlipEnd;
      SLOT_DATA:     r = esc_first(cmd.data);
      SLOT_DATA_ESC: r = esc_second(cmd.data);
      SLOT_CRCL:     r = esc_first(cmd.crc[7:0]);
      SLOT_CRCL_ESC: r = esc_second(cmd.crc[7:0]);
      SLOT_CRCH:     r = esc_first(cmd.crc[15:8]);
      SLOT_CRCH_ESC: r = esc_second(cmd.crc[15:8]);
      SLOT_CLOSE:    r = SlipEnd;
      default:       r = SlipEnd;
    endcase
    return r;
  endfunction

endpackage

### src/sfe_front.sv
module sfe_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        payload_byte_i,
  input  logic              end_of_payload_i,
  input  logic              empty_frame_i,
  output sfe_pkg::cmd_t     cmd_o
);

  logic        in_frame_q, in_frame_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_new;
  logic        has_byte, closing;

  always_comb begin
    has_byte = !empty_frame_i;
    closing  = empty_frame_i || end_of_payload_i;
    crc_new  = has_byte ? sfe_pkg::crc_fold(crc_q, payload_byte_i) : crc_q;

    cmd_o.data = payload_byte_i;
    cmd_o.crc  = crc_new;
    cmd_o.mask = '0;
    cmd_o.mask[sfe_pkg::SLOT_OPEN]     = !in_frame_q;
    cmd_o.mask[sfe_pkg::SLOT_DATA]     = has_byte;
    cmd_o.mask[sfe_pkg::SLOT_DATA_ESC] = has_byte && sfe_pkg::needs_esc(payload_byte_i);
    cmd_o.mask[sfe_pkg::SLOT_CRCL]     = closing;
    cmd_o.mask[sfe_pkg::SLOT_CRCL_ESC] = closing && sfe_pkg::needs_esc(crc_new[7:0]);
    cmd_o.mask[sfe_pkg::SLOT_CRCH]     = closing;
    cmd_o.mask[sfe_pkg::SLOT_CRCH_ESC] = closing && sfe_pkg::needs_esc(crc_new[15:8]);
    cmd_o.mask[sfe_pkg::SLOT_CLOSE]    = closing;

    in_frame_d = in_frame_q;
    crc_d      = crc_q;
    if (accept_i) begin
      // close returns the CRC to its seed for the next frame
      in_frame_d = !closing;
      crc_d      = closing ? sfe_pkg::CrcSeed : crc_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      crc_q      <= sfe_pkg::CrcSeed;
    end else begin
      in_frame_q <= in_frame_d;
      crc_q      <= crc_d;
    end
  end

endmodule

### src/sfe_queue.sv
module sfe_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfe_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output sfe_pkg::cmd_t cmd_o,
  output logic          empty_o
);

  sfe_pkg::cmd_t                  mem_q [sfe_pkg::QDepth];
  logic [sfe_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [sfe_pkg::QCntW-1:0]      cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == sfe_pkg::QCntW'(sfe_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == sfe_pkg::QPtrW'(sfe_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == sfe_pkg::QPtrW'(sfe_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### src/sfe_back.sv
module sfe_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sfe_pkg::cmd_t q_cmd_i,
  input  logic          q_empty_i,
  output logic          q_pop_o,
  output logic [7:0]    wire_byte_o,
  output logic          last_of_run_o,
  output logic          frame_done_o,
  output logic          empty_o,
  input  logic          pop_i
);

  sfe_pkg::cmd_t                 cmd_q, cmd_d;
  logic [sfe_pkg::NumSlots-1:0]  mask_q, mask_d;
  logic [sfe_pkg::NumSlots-1:0]  sel, rem;
  sfe_pkg::slot_e                slot;
  logic                          out_valid_q, out_valid_d;
  logic [7:0]                    byte_q, byte_d;
  logic                          last_q, last_d, done_q, done_d;
  logic                          advance, emit;

  always_comb begin
    slot = sfe_pkg::SLOT_CLOSE;
    for (int i = sfe_pkg::NumSlots - 1; i >= 0; i--) begin
      if (mask_q[i]) slot = sfe_pkg::slot_e'(i);
    end
  end

  assign sel     = mask_q & (~mask_q + 1'b1);
  assign advance = !out_valid_q || pop_i;
  assign emit    = advance && (mask_q != '0);

  always_comb begin
    rem         = emit ? (mask_q & ~sel) : mask_q;
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    last_d      = last_q;
    done_d      = done_q;
    if (advance) begin
      out_valid_d = emit;
      byte_d      = sfe_pkg::slot_byte(slot, cmd_q);
      last_d      = (mask_q & ~sel) == '0;
      done_d      = (slot == sfe_pkg::SLOT_CLOSE);
    end
    // load the next item as soon as the current one has no byte left
    q_pop_o = (rem == '0) && !q_empty_i;
    mask_d  = q_pop_o ? q_cmd_i.mask : rem;
    cmd_d   = q_pop_o ? q_cmd_i : cmd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    byte_q <= byte_d;
    last_q <= last_d;
    done_q <= done_d;
  end

  assign wire_byte_o   = byte_q;
  assign last_of_run_o = last_q;
  assign frame_done_o  = done_q;
  assign empty_o       = !out_valid_q;

  a_done_is_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> last_q && (byte_q == sfe_pkg::SlipEnd))
    else $error("closing delimiter not last or not C0");

  a_no_dangling_esc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q && !done_q |-> byte_q != sfe_pkg::SlipEsc)
    else $error("item ends on an escape byte");

  a_held_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop_i |=> out_valid_q)
    else $error("waiting result dropped");

  a_no_load_over_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (rem == '0))
    else $error("item loaded over unfinished bytes");

endmodule

### src/slip_frame_encoder_crc16.sv
// Channel  | Handshake            | Fields
// input    | push / full          | payload_byte_i, end_of_payload_i, empty_frame_i
// result   | pop / empty          | wire_byte_o, last_of_run_o, frame_done_o
//
// An item enters when accepted; the front updates the CRC and queues one command.
// The back emits one wire byte per cycle unless a held result stalls it; an item
// gives 1 to 8 wire bytes, with no gap between items while the queue holds more.
// Reset clears the open-frame flag, seeds the CRC with 0xFFFF and empties the queue.
// full rises when the two-entry command queue is full; a held result (pop low)
// stalls the back while the front keeps taking items until the queue fills.
module slip_frame_encoder_crc16 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] payload_byte_i,
  input  logic       end_of_payload_i,
  input  logic       empty_frame_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] wire_byte_o,
  output logic       last_of_run_o,
  output logic       frame_done_o
);

  sfe_pkg::cmd_t front_cmd, q_cmd;
  logic          accept, q_empty, q_pop;

  assign accept = push && !full;

  sfe_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .payload_byte_i   (payload_byte_i),
    .end_of_payload_i (end_of_payload_i),
    .empty_frame_i    (empty_frame_i),
    .cmd_o            (front_cmd)
  );

  sfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd),
    .empty_o (q_empty)
  );

  sfe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_cmd_i       (q_cmd),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .wire_byte_o   (wire_byte_o),
    .last_of_run_o (last_of_run_o),
    .frame_done_o  (frame_done_o),
    .empty_o       (empty),
    .pop_i         (pop)
  );

endmodule
